// ----- design/cood_pkg.sv -----
// ----------------------------------------------------------------------------
// cood_pkg
// shared beat types, register codes and reset values for the
// cfar onset / offset detector
// ----------------------------------------------------------------------------
package cood_pkg;

    localparam int ENERGY_W   = 32;
    localparam int CENTROID_W = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ONSET_FACTOR  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_FACTOR    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_FRAMES = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_FRAMES    = 4'd3;

    // register reset values
    localparam logic [7:0]  ONSET_FACTOR_RST  = 8'd160;
    localparam logic [15:0] END_FACTOR_RST    = 16'd19661;
    localparam logic [7:0]  SETTLE_FRAMES_RST = 8'd25;
    localparam logic [9:0]  END_FRAMES_RST    = 10'd100;

    // event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ONSET  = 2'd1;
    localparam logic [1:0] EV_OFFSET = 2'd2;

    typedef struct packed {
        logic [ENERGY_W-1:0]   frame_energy;
        logic [CENTROID_W-1:0] centroid_hz;
    } in_beat_t;

    typedef struct packed {
        logic       active;
        logic [1:0] event_res;
        logic       tracking;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  onset_factor;
        logic [15:0] end_factor;
        logic [7:0]  settle_frames;
        logic [9:0]  end_frames;
    } cfg_t;

endpackage

// ----- design/cood_window.sv -----
// ----------------------------------------------------------------------------
// cood_window
// energy history line with running window sum and cell-averaging onset test
// ----------------------------------------------------------------------------
module cood_window #(
    parameter int WINDOW = 20,
    parameter int GUARD  = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [cood_pkg::ENERGY_W-1:0] energy,
    input  cood_pkg::cfg_t                cfg,
    output logic                          onset
);

    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = cood_pkg::ENERGY_W + $clog2(WINDOW);
    localparam int CMP_W     = SUM_W + 8;
    localparam int CNT       = (GUARD < WINDOW) ? (WINDOW - GUARD) : 0;
    localparam int ENTER_IDX = (GUARD >= 2 && GUARD < WINDOW) ? (GUARD - 2) : 0;
    localparam int LEAVE_IDX = WINDOW - 2;
    localparam logic [CMP_W-1:0]  SCALE   = CMP_W'(CNT * 16);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

    logic [cood_pkg::ENERGY_W-1:0] hist_reg [0:WINDOW-2];
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;
    logic [SUM_W-1:0]              test_sum;
    logic [SUM_W-1:0]              enter_val;
    logic [SUM_W-1:0]              leave_val;
    logic [CMP_W-1:0]              lhs;
    logic [CMP_W-1:0]              rhs;
    logic                          full;

    assign full = (fill_reg >= FILL_W'(WINDOW - 1));

    always_comb
    begin
        if (GUARD <= 1)
        begin
            enter_val = SUM_W'(energy);
        end
        else if (fill_reg > FILL_W'(ENTER_IDX))
        begin
            enter_val = SUM_W'(hist_reg[ENTER_IDX]);
        end
        else
        begin
            enter_val = '0;
        end
        leave_val = (fill_reg > FILL_W'(LEAVE_IDX)) ? SUM_W'(hist_reg[LEAVE_IDX]) : '0;
        sum_next  = sum_reg + enter_val - leave_val;
        fill_next = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
        test_sum  = (GUARD == 0) ? (sum_reg + SUM_W'(energy)) : sum_reg;
        lhs       = CMP_W'(energy) * SCALE;
        rhs       = CMP_W'(cfg.onset_factor) * CMP_W'(test_sum);
        if (!full)
        begin
            onset = 1'b0;
        end
        else if (GUARD >= WINDOW)
        begin
            onset = (energy != '0);
        end
        else
        begin
            onset = (lhs > rhs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (push)
        begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // history line, newest first
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hist_reg[0] <= energy;
            for (int k = 1; k <= WINDOW - 2; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

endmodule

// ----- design/cood_tracker.sv -----
// ----------------------------------------------------------------------------
// cood_tracker
// end tracking: ema reference energy, low frame count and offset decision
// ----------------------------------------------------------------------------
module cood_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [cood_pkg::ENERGY_W-1:0]   energy,
    input  logic [cood_pkg::CENTROID_W-1:0] centroid,
    input  cood_pkg::cfg_t                  cfg,
    output logic                            offset
);

    logic [cood_pkg::ENERGY_W-1:0] ref_reg;
    logic                          ref_valid_reg;
    logic [9:0]                    low_count_reg;
    logic [9:0]                    low_inc;
    logic [47:0]                   lhs;
    logic [47:0]                   rhs;
    logic                          is_low;
    logic [35:0]                   ema_sum;
    logic [19:0]                   ema_fold;
    logic [39:0]                   ema_fold_q;
    logic [33:0]                   ema_quot;
    logic [cood_pkg::ENERGY_W-1:0] ema;

    always_comb
    begin
        lhs      = {energy, 16'h0000};
        rhs      = 48'(ref_reg) * 48'(cfg.end_factor);
        is_low   = (lhs < rhs) || (centroid == '0);
        low_inc  = (low_count_reg == 10'h3ff) ? low_count_reg : low_count_reg + 10'd1;
        offset   = ref_valid_reg && is_low && (low_inc >= cfg.end_frames);
        // rounded 0.9 / 0.1 blend: (9 * ref + energy + 5) / 10
        // split at bit 18 since 2^18 = 10 * 26214 + 4, low part by reciprocal 0xccccd >> 23
        ema_sum    = 36'(ref_reg) * 36'd9 + 36'(energy) + 36'd5;
        ema_fold   = {ema_sum[35:18], 2'b00} + {2'b00, ema_sum[17:0]};
        ema_fold_q = {20'd0, ema_fold} * 40'd838861;
        ema_quot   = 34'(ema_sum[35:18]) * 34'd26214 + {17'd0, ema_fold_q[39:23]};
        ema        = ema_quot[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= '0;
            ref_valid_reg <= 1'b0;
            low_count_reg <= '0;
        end
        else if (step)
        begin
            if (!ref_valid_reg)
            begin
                ref_reg       <= energy;
                ref_valid_reg <= 1'b1;
                low_count_reg <= '0;
            end
            else if (offset)
            begin
                ref_reg       <= '0;
                ref_valid_reg <= 1'b0;
                low_count_reg <= '0;
            end
            else if (is_low)
            begin
                low_count_reg <= low_inc;
            end
            else
            begin
                low_count_reg <= '0;
                ref_reg       <= ema;
            end
        end
    end

endmodule

// ----- design/cfar_onset_offset_detector_top.sv -----
// ----------------------------------------------------------------------------
// cfar_onset_offset_detector_top
// cell-averaging cfar onset detector with settle and ema-based offset tracking
// ----------------------------------------------------------------------------
// One frame beat enters per cycle, while the receiver does not stall, and
// yields one result beat. A taken beat lands in the input register, is
// evaluated in a single pass when it advances (window sum, onset compare,
// settle count, reference compare and ema update) and shows up in the
// result register. The result register holds a stalled result while the
// input register keeps taking one more beat.
// The window sum is kept as a running sum of the history line, so the onset
// test needs a full window of idle frames first. Write registers only while
// the block is idle.
module cfar_onset_offset_detector_top #(
    parameter int WINDOW = 20,
    parameter int GUARD  = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  cood_pkg::in_beat_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cood_pkg::out_beat_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cood_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cood_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SETTLE = 2'd1;
    localparam logic [1:0] MODE_TRACK  = 2'd2;

    cood_pkg::cfg_t      cfg_reg;
    cood_pkg::in_beat_t  s1_data_reg;
    logic                s1_valid_reg;
    cood_pkg::out_beat_t out_data_reg;
    cood_pkg::out_beat_t out_data_next;
    logic                out_valid_reg;
    logic [1:0]          mode_reg;
    logic [1:0]          mode_next;
    logic [7:0]          settle_count_reg;
    logic [7:0]          settle_count_next;
    logic [7:0]          settle_inc;
    logic                advance;
    logic                in_take;
    logic                run_track;
    logic                push;
    logic                onset;
    logic                offset;
    logic [1:0]          ev;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign settle_inc = (settle_count_reg < cfg_reg.settle_frames)
                        ? settle_count_reg + 8'd1 : settle_count_reg;
    assign run_track  = ((mode_reg == MODE_SETTLE) && (settle_inc >= cfg_reg.settle_frames))
                        || (mode_reg == MODE_TRACK);
    assign push       = advance && (mode_reg == MODE_IDLE);

    cood_window #(
        .WINDOW (WINDOW),
        .GUARD  (GUARD)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .energy (s1_data_reg.frame_energy),
        .cfg    (cfg_reg),
        .onset  (onset)
    );

    cood_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance && run_track),
        .energy   (s1_data_reg.frame_energy),
        .centroid (s1_data_reg.centroid_hz),
        .cfg      (cfg_reg),
        .offset   (offset)
    );

    always_comb
    begin
        mode_next         = mode_reg;
        settle_count_next = settle_count_reg;
        ev                = cood_pkg::EV_NONE;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (onset)
                begin
                    mode_next         = MODE_SETTLE;
                    settle_count_next = '0;
                    ev                = cood_pkg::EV_ONSET;
                end
            end
            MODE_SETTLE:
            begin
                settle_count_next = settle_inc;
                if (run_track)
                begin
                    mode_next = MODE_TRACK;
                end
            end
            MODE_TRACK:
            begin
                mode_next = MODE_TRACK;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
        if (run_track && offset)
        begin
            mode_next         = MODE_IDLE;
            settle_count_next = '0;
            ev                = cood_pkg::EV_OFFSET;
        end
        out_data_next.active    = (mode_next != MODE_IDLE);
        out_data_next.event_res = ev;
        out_data_next.tracking  = (mode_next == MODE_TRACK);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= MODE_IDLE;
            settle_count_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                mode_reg         <= mode_next;
                settle_count_reg <= settle_count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beat payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.onset_factor  <= cood_pkg::ONSET_FACTOR_RST;
            cfg_reg.end_factor    <= cood_pkg::END_FACTOR_RST;
            cfg_reg.settle_frames <= cood_pkg::SETTLE_FRAMES_RST;
            cfg_reg.end_frames    <= cood_pkg::END_FRAMES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cood_pkg::REG_ONSET_FACTOR:  cfg_reg.onset_factor  <= cfg_data[7:0];
                cood_pkg::REG_END_FACTOR:    cfg_reg.end_factor    <= cfg_data[15:0];
                cood_pkg::REG_SETTLE_FRAMES: cfg_reg.settle_frames <= cfg_data[7:0];
                cood_pkg::REG_END_FRAMES:    cfg_reg.end_frames    <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- verif/cfar_detector_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfar_detector_monitor
// Watches the frame, result and register channels of the cfar onset / offset
// detector. It keeps its own copy of the window history, the mode machine and
// the end tracker, works out the result of every accepted frame beat, and
// compares each accepted result beat field by field with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module cfar_detector_monitor #(
    parameter int WINDOW = 20,
    parameter int GUARD  = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  cood_pkg::in_beat_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  cood_pkg::out_beat_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cood_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cood_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              frames_seen,
    output int                              onsets_seen,
    output int                              offsets_seen,
    output int                              reg_writes
);

    typedef enum logic [1:0] {DET_IDLE, DET_SETTLE, DET_TRACK} det_mode_t;

    logic [7:0]  onset_factor;
    logic [15:0] end_factor;
    logic [7:0]  settle_frames;
    logic [9:0]  end_frames;

    logic [31:0] energy_hist [WINDOW];
    int          hist_ptr;
    int          hist_fill;
    det_mode_t   mode;
    logic [7:0]  settle_cnt;
    logic [31:0] ref_energy;
    logic        ref_valid;
    logic [9:0]  low_cnt;

    cood_pkg::out_beat_t result_q [$];
    cood_pkg::out_beat_t want;
    int                  results_seen;

    task automatic report_mismatch(input string field, input int got, input int wanted);
        fail_count++;
        $display("mismatch at result %0d: %s is %0d, expected %0d",
                 results_seen, field, got, wanted);
    endtask

    // history only moves on idle frames
    function automatic logic window_onset(input logic [31:0] e);
        logic [63:0] sum;
        logic [63:0] lhs;
        sum = '0;
        energy_hist[hist_ptr] = e;
        hist_ptr = (hist_ptr + 1) % WINDOW;
        if (hist_fill < WINDOW)
            hist_fill++;
        if (hist_fill < WINDOW)
            return 1'b0;
        if (GUARD >= WINDOW)
            return e != '0;
        for (int i = GUARD; i < WINDOW; i++)
            sum += 64'(energy_hist[(hist_ptr + 2 * WINDOW - 1 - i) % WINDOW]);
        lhs = 64'(e) * 64'(WINDOW - GUARD) * 64'd16;
        return lhs > 64'(onset_factor) * sum;
    endfunction

    // returns 1 on offset
    function automatic logic end_step(input logic [31:0] e, input logic [15:0] c);
        if (!ref_valid)
        begin
            ref_energy = e;
            ref_valid  = 1'b1;
            low_cnt    = '0;
            return 1'b0;
        end
        if ((64'(e) << 16) < 64'(ref_energy) * 64'(end_factor) || c == '0)
        begin
            if (low_cnt < 10'd1023)
                low_cnt++;
            return low_cnt >= end_frames;
        end
        low_cnt    = '0;
        ref_energy = 32'((64'd9 * 64'(ref_energy) + 64'(e) + 64'd5) / 64'd10);
        return 1'b0;
    endfunction

    function automatic cood_pkg::out_beat_t predict_frame(input cood_pkg::in_beat_t f);
        cood_pkg::out_beat_t r;
        logic                do_track;
        logic [1:0]          ev;
        ev       = cood_pkg::EV_NONE;
        do_track = 1'b0;
        case (mode)
            DET_SETTLE:
            begin
                if (settle_cnt < settle_frames)
                    settle_cnt++;
                if (settle_cnt >= settle_frames)
                begin
                    mode     = DET_TRACK;
                    do_track = 1'b1;
                end
            end
            DET_TRACK:
                do_track = 1'b1;
            default:
            begin
                mode = DET_IDLE;
                if (window_onset(f.frame_energy))
                begin
                    mode       = DET_SETTLE;
                    settle_cnt = '0;
                    ev         = cood_pkg::EV_ONSET;
                end
            end
        endcase
        if (do_track && end_step(f.frame_energy, f.centroid_hz))
        begin
            mode       = DET_IDLE;
            settle_cnt = '0;
            ref_energy = '0;
            ref_valid  = 1'b0;
            low_cnt    = '0;
            ev         = cood_pkg::EV_OFFSET;
        end
        r.active    = (mode != DET_IDLE);
        r.event_res = ev;
        r.tracking  = (mode == DET_TRACK);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            onset_factor  = cood_pkg::ONSET_FACTOR_RST;
            end_factor    = cood_pkg::END_FACTOR_RST;
            settle_frames = cood_pkg::SETTLE_FRAMES_RST;
            end_frames    = cood_pkg::END_FRAMES_RST;
            for (int i = 0; i < WINDOW; i++)
                energy_hist[i] = '0;
            hist_ptr      = 0;
            hist_fill     = 0;
            mode          = DET_IDLE;
            settle_cnt    = '0;
            ref_energy    = '0;
            ref_valid     = 1'b0;
            low_cnt       = '0;
            result_q.delete();
            results_seen  = 0;
            fail_count    = 0;
            frames_seen   = 0;
            onsets_seen   = 0;
            offsets_seen  = 0;
            reg_writes    = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cood_pkg::REG_ONSET_FACTOR:  onset_factor  = cfg_data[7:0];
                    cood_pkg::REG_END_FACTOR:    end_factor    = cfg_data;
                    cood_pkg::REG_SETTLE_FRAMES: settle_frames = cfg_data[7:0];
                    cood_pkg::REG_END_FRAMES:    end_frames    = cfg_data[9:0];
                    default: ;
                endcase
                reg_writes++;
            end
            // result side first: a beat taken now cannot come out this edge
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                    report_mismatch("result beat with none outstanding", int'(out_data), 0);
                else
                begin
                    want = result_q.pop_front();
                    if (out_data.active !== want.active)
                        report_mismatch("active", int'(out_data.active), int'(want.active));
                    if (out_data.event_res !== want.event_res)
                        report_mismatch("event_res", int'(out_data.event_res),
                                        int'(want.event_res));
                    if (out_data.tracking !== want.tracking)
                        report_mismatch("tracking", int'(out_data.tracking),
                                        int'(want.tracking));
                    if (want.event_res == cood_pkg::EV_ONSET)
                        onsets_seen++;
                    if (want.event_res == cood_pkg::EV_OFFSET)
                        offsets_seen++;
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                result_q.push_back(predict_frame(in_data));
                frames_seen++;
            end
            pending <= result_q.size();
        end
    end

endmodule

// ----- verif/tb_cfar_onset_offset_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cfar_onset_offset_detector_top
// Drives frame beats into the detector: a short directed run over the field
// extremes and every event, then phases of random scenes (background, onset
// spike, sustain, decay) mixed with noise frames, each phase under its own
// register setting and idling pattern. A separate monitor predicts and checks
// every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_cfar_onset_offset_detector_top;

    localparam int WINDOW          = 20;
    localparam int GUARD           = 2;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam logic [cood_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd12;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    cood_pkg::in_beat_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    cood_pkg::out_beat_t             out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [cood_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cood_pkg::CFG_DATA_W-1:0] cfg_data;

    int          idle_pct     = 0;
    int          stall_pct    = 0;
    bit          hold_off_req = 1'b0;
    int          quiet        = 0;
    logic [7:0]  cur_settle;
    logic [9:0]  cur_end;

    int mon_fails;
    int mon_pending;
    int mon_frames;
    int mon_onsets;
    int mon_offsets;
    int mon_writes;

    cfar_onset_offset_detector_top #(
        .WINDOW (WINDOW),
        .GUARD  (GUARD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfar_detector_monitor #(
        .WINDOW (WINDOW),
        .GUARD  (GUARD)
    ) u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (mon_fails),
        .pending      (mon_pending),
        .frames_seen  (mon_frames),
        .onsets_seen  (mon_onsets),
        .offsets_seen (mon_offsets),
        .reg_writes   (mon_writes)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stall, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("cfar_onset_offset_detector_top test failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic [31:0] jitter(input logic [31:0] v);
        return v - (v >> 3) + ($urandom % ((v >> 2) + 1));
    endfunction

    task automatic send_frame(input logic [31:0] e, input logic [15:0] c);
        cood_pkg::in_beat_t beat;
        beat.frame_energy = e;
        beat.centroid_hz  = c;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [cood_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cood_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] of, input logic [15:0] ef,
                              input logic [15:0] sf, input logic [15:0] efr);
        write_reg(cood_pkg::REG_ONSET_FACTOR, of);
        write_reg(cood_pkg::REG_END_FACTOR, ef);
        write_reg(cood_pkg::REG_SETTLE_FRAMES, sf);
        write_reg(cood_pkg::REG_END_FRAMES, efr);
        cfg_valid  <= 1'b0;
        cur_settle  = sf[7:0];
        cur_end     = efr[9:0];
    endtask

    // wait until every result beat is back, then the pipeline latency
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mon_pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_traffic(input int total);
        int          sent;
        int          k;
        int          bg_len;
        int          hold_len;
        int          tail_len;
        logic [31:0] level;
        logic [31:0] peak;
        logic [31:0] e;
        logic [15:0] c;
        sent = 0;
        while (sent < total)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                // noise frames, extremes included
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    case ($urandom_range(0, 9))
                        0: e = '0;
                        1: e = '1;
                        default: e = $urandom;
                    endcase
                    c = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
                    send_frame(e, c);
                end
                sent += k;
            end
            else
            begin
                // background, spike, sustain, decay
                level    = $urandom_range(32'h0000_0400, 32'h0010_0000);
                bg_len   = $urandom_range(3, 24);
                hold_len = ((cur_settle > 60) ? 60 : cur_settle) + $urandom_range(1, 12);
                tail_len = (cur_end > 120) ? $urandom_range(5, 40)
                                           : cur_end + $urandom_range(0, 3);
                if ($urandom_range(0, 99) < 20)
                    tail_len = tail_len / 2;
                repeat (bg_len)
                    send_frame(jitter(level), 16'($urandom_range(200, 8000)));
                peak = level * $urandom_range(20, 40);
                send_frame(peak, 16'($urandom_range(200, 8000)));
                repeat (hold_len)
                    send_frame(jitter(peak), 16'($urandom_range(200, 8000)));
                repeat (tail_len)
                begin
                    e = $urandom_range(0, peak >> 3);
                    c = ($urandom_range(0, 3) == 0) ? 16'd0
                                                   : 16'($urandom_range(200, 8000));
                    send_frame(e, c);
                end
                sent += bg_len + 1 + hold_len + tail_len;
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall,
                             input logic [15:0] of, input logic [15:0] ef,
                             input logic [15:0] sf, input logic [15:0] efr,
                             input int frames, input bit pressure);
        drain();
        set_config(of, ef, sf, efr);
        idle_pct  = idle;
        stall_pct = stall;
        if (pressure)
            hold_off_req = 1'b1;
        random_traffic(frames);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_settle = cood_pkg::SETTLE_FRAMES_RST;
        cur_end    = cood_pkg::END_FRAMES_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset thresholds, short settle and end
        write_reg(cood_pkg::REG_SETTLE_FRAMES, 16'd1);
        write_reg(cood_pkg::REG_END_FRAMES, 16'd2);
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_valid  <= 1'b0;
        cur_settle  = 8'd1;
        cur_end     = 10'd2;
        repeat (18)
            send_frame(32'h0001_0000, 16'd1000);
        send_frame(32'h0000_0000, 16'h0000);
        send_frame(32'hFFFF_FFFF, 16'hFFFF);
        send_frame(32'hFFFF_FFFF, 16'hFFFF);
        send_frame(32'hFFFF_FFFF, 16'h0000);
        send_frame(32'hFFFF_FFFF, 16'hFFFF);
        send_frame(32'h0000_0000, 16'd500);
        send_frame(32'h0000_0000, 16'h0000);

        run_phase(0, 0, 16'd24, 16'd19661, 16'd3, 16'd5, 280, 1'b1);
        run_phase(71, 0, 16'd255, 16'hFFFF, 16'd1, 16'd1, 250, 1'b0);
        run_phase(0, 71, 16'd0, 16'd0, 16'h0100, 16'h0400, 250, 1'b0);
        run_phase(28, 28, 16'd40, 16'd32768, 16'd8, 16'd10, 280, 1'b1);
        run_phase(0, 0, 16'(cood_pkg::ONSET_FACTOR_RST), cood_pkg::END_FACTOR_RST,
                  16'(cood_pkg::SETTLE_FRAMES_RST), 16'(cood_pkg::END_FRAMES_RST),
                  250, 1'b0);
        run_phase(28, 28, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 160, 1'b0);
        drain();

        $display("run covered %0d frames with %0d onsets and %0d offsets, %0d register writes",
                 mon_frames, mon_onsets, mon_offsets, mon_writes);
        $display("idling: none, sender only, receiver only, both, with long receiver hold-offs");
        if (mon_fails == 0)
            $display("cfar_onset_offset_detector_top test passed");
        else
            $display("cfar_onset_offset_detector_top test failed");
        $finish;
    end

endmodule
